// ----- rtl/core/cie94_pkg.sv -----
// Shared types, constants and elaboration-time tables for the CIE94 delta-E pipeline.
// Depends on nothing; imported by the top level, cie94_cbrt and cie94_lab.
package cie94_pkg;

    localparam int LIN_W = 17;   // linear sRGB, unsigned Q1.16
    localparam int F_W   = 25;   // Lab function values, unsigned Q24 up to 1.0
    localparam int F_FRAC = 24;
    localparam int LAB_W = 16;   // signed Q8.8
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K2 = 2'd2;

    localparam logic [13:0] KL_RESET = 14'd4096;
    localparam logic [15:0] K1_RESET = 16'd2949;
    localparam logic [15:0] K2_RESET = 16'd983;

    // D65 matrix scaled by 1e7 (x100 then per-mille of the Q16 input)
    localparam logic [23:0] MAT [3][3] = '{
        '{24'd4124564, 24'd3575761, 24'd1804375},
        '{24'd2126729, 24'd7151522, 24'd721750},
        '{24'd193339,  24'd1191920, 24'd9503041}
    };
    localparam logic [23:0] WHITE_DEN [3] = '{24'd9504700, 24'd10000000, 24'd10888300};

    // linear segment of the Lab function: (v*24389 + 432<<24 + 1566) / 3132
    localparam logic [11:0] LSEG_DEN = 12'd3132;
    localparam logic [14:0] LSEG_MUL = 15'd24389;
    localparam logic [39:0] LSEG_OFS = (40'd432 << 24) + 40'd1566;
    localparam logic [39:0] LSEG_LIM = 40'd216 << 24;

    typedef logic [LIN_W-1:0] t_lin;
    typedef t_lin t_lin_tab [256];

    typedef struct packed {
        logic signed [LAB_W-1:0] l;
        logic signed [LAB_W-1:0] a;
        logic signed [LAB_W-1:0] b;
    } t_lab;

    function automatic longint unsigned lin_pow5(input longint unsigned y);
        longint unsigned y2, y4;
        y2 = (y * y) >> 30;
        y4 = (y2 * y2) >> 30;
        return (y4 * y) >> 30;
    endfunction

    // sRGB curve for one code, evaluated at elaboration
    function automatic t_lin lin_calc(input int unsigned c);
        longint unsigned cl, tq, t2, lo, hi, mid, r;
        cl = longint'(c);
        if (c <= 10) begin
            r = (cl * 64'd6553600 + 64'd164730) / 64'd329460;
        end else begin
            tq = (((cl * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
            t2 = (tq * tq) >> 30;
            lo = 0;
            hi = 64'd1 << 30;
            for (int i = 0; i < 34; i++) begin
                if (lo < hi) begin
                    mid = lo + (hi - lo + 64'd1) / 64'd2;
                    if (lin_pow5(mid) <= t2) lo = mid;
                    else hi = mid - 64'd1;
                end
            end
            r = (((t2 * lo) >> 30) + 64'd8192) >> 14;
        end
        return r[LIN_W-1:0];
    endfunction

    function automatic t_lin_tab lin_build();
        t_lin_tab t;
        for (int unsigned c = 0; c < 256; c++) t[c] = lin_calc(c);
        return t;
    endfunction

    localparam t_lin_tab LIN_TAB = lin_build();

    // round half away from zero from Q24 to Q8.8, saturate to int16
    function automatic logic signed [LAB_W-1:0] to_q8(input logic signed [35:0] x);
        logic [35:0] m;
        logic [19:0] r;
        m = x[35] ? 36'(-x) : 36'(x);
        r = 20'((m + 36'd32768) >> 16);
        if (!x[35]) begin
            return (r > 20'd32767) ? 16'sd32767 : $signed(r[15:0]);
        end
        return (r > 20'd32768) ? -16'sd32768 : $signed(16'(20'(-r)));
    endfunction

endpackage

// ----- rtl/core/rgb_pair_cie94_delta_e.sv -----
// CIE94 color difference of two 8-bit sRGB colors, result in unsigned Q8.8.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) empties all stages and restores kL=1.0,
// K1=0.045, K2=0.015.
module rgb_pair_cie94_delta_e
    import cie94_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_red_first,
    input  logic [7:0]            i_green_first,
    input  logic [7:0]            i_blue_first,
    input  logic [7:0]            i_red_second,
    input  logic [7:0]            i_green_second,
    input  logic [7:0]            i_blue_second,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [15:0]           o_delta_e_q8,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic        en;
    logic [13:0] r_kl;
    logic [15:0] r_k1, r_k2;

    logic        w_lab_vld, w_c_vld, w_dh_vld, w_t_vld;
    t_lab        w_p, w_q;

    logic        r_v1, r_v2, r_v3, r_v5, r_v6, r_out_vld;
    logic [15:0] r_dl, r_da, r_db;
    logic [31:0] r_s1, r_s2;
    logic [15:0] r_dl2, r_dc2;
    logic [32:0] r_sab;
    logic [31:0] r_kc1, r_kh1;
    logic [15:0] r_dl3, r_dc3;
    logic [32:0] r_dhv;
    logic [24:0] r_sc, r_sh;
    logic [57:0] r_tl2, r_tc2, r_th2;
    logic [59:0] r_sum;
    logic [15:0] r_out;

    logic [15:0] w_c1, w_c2, w_dl_c;
    logic [47:0] w_side_c;
    logic [16:0] w_dh;
    logic [81:0] w_side_dh;
    logic [28:0] w_tl, w_tc, w_th;
    logic [29:0] w_res;
    logic        w_res_vld;

    logic [15:0] n_dl, n_da, n_db, n_dc;
    logic [33:0] n_dh2;
    logic [13:0] w_kl;
    logic [33:0] n_tl_num, n_tc_num, n_th_num;

    function automatic logic [15:0] mag16(input logic signed [15:0] x);
        return x[15] ? 16'(-x) : 16'(x);
    endfunction

    function automatic logic [15:0] dmag(input logic signed [15:0] x, input logic signed [15:0] y);
        logic signed [16:0] d;
        d = $signed({x[15], x}) - $signed({y[15], y});
        return d[16] ? 16'(-d) : 16'(d);
    endfunction

    // hold every stage while a finished result is not taken
    assign en = !r_out_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kl <= KL_RESET;
            r_k1 <= K1_RESET;
            r_k2 <= K2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KL:  r_kl <= i_cfg_data[13:0];
                CFG_K1:  r_k1 <= i_cfg_data;
                CFG_K2:  r_k2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cie94_lab u_lab_first (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_red(i_red_first), .i_green(i_green_first), .i_blue(i_blue_first),
        .o_vld(w_lab_vld), .o_lab(w_p)
    );

    cie94_lab u_lab_second (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_red(i_red_second), .i_green(i_green_second), .i_blue(i_blue_second),
        .o_vld(), .o_lab(w_q)
    );

    assign n_dl = dmag(w_p.l, w_q.l);
    assign n_da = dmag(w_p.a, w_q.a);
    assign n_db = dmag(w_p.b, w_q.b);

    // chroma of both colors
    cie94_sqrt #(.VW(32), .SW(48)) u_sqrt_c1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v1), .i_val(r_s1),
        .i_side({r_dl, r_da, r_db}),
        .o_vld(w_c_vld), .o_root(w_c1), .o_side(w_side_c)
    );

    cie94_sqrt #(.VW(32), .SW(1)) u_sqrt_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v1), .i_val(r_s2),
        .i_side(1'b0), .o_vld(), .o_root(w_c2), .o_side()
    );

    assign w_dl_c = w_side_c[47:32];
    assign n_dc = (w_c1 >= w_c2) ? (w_c1 - w_c2) : (w_c2 - w_c1);
    assign n_dh2 = {1'b0, r_sab} - 34'(32'(r_dc2) * 32'(r_dc2));

    cie94_sqrt #(.VW(33), .SW(82)) u_sqrt_dh (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v3), .i_val(r_dhv),
        .i_side({r_dl3, r_dc3, r_sc, r_sh}),
        .o_vld(w_dh_vld), .o_root(w_dh), .o_side(w_side_dh)
    );

    // a zero weight counts as one code
    assign w_kl = (r_kl == '0) ? 14'd1 : r_kl;
    assign n_tl_num = (34'(w_side_dh[81:66]) << 12) + 34'(w_kl >> 1);
    assign n_tc_num = (34'(w_side_dh[65:50]) << 16) + 34'(w_side_dh[49:25] >> 1);
    assign n_th_num = (34'(w_dh) << 16) + 34'(w_side_dh[24:0] >> 1);

    cie94_div #(.NW(34), .DW(25), .QW(29), .SW(1)) u_div_tl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(w_dh_vld),
        .i_num(n_tl_num), .i_den(25'(w_kl)), .i_side(1'b0),
        .o_vld(w_t_vld), .o_quo(w_tl), .o_side()
    );

    cie94_div #(.NW(34), .DW(25), .QW(29), .SW(1)) u_div_tc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(w_dh_vld),
        .i_num(n_tc_num), .i_den(w_side_dh[49:25]), .i_side(1'b0),
        .o_vld(), .o_quo(w_tc), .o_side()
    );

    cie94_div #(.NW(34), .DW(25), .QW(29), .SW(1)) u_div_th (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(w_dh_vld),
        .i_num(n_th_num), .i_den(w_side_dh[24:0]), .i_side(1'b0),
        .o_vld(), .o_quo(w_th), .o_side()
    );

    cie94_sqrt #(.VW(60), .SW(1)) u_sqrt_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v6), .i_val(r_sum),
        .i_side(1'b0), .o_vld(w_res_vld), .o_root(w_res), .o_side()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_out_vld <= 1'b0;
        end else if (en) begin
            r_v1 <= w_lab_vld;
            r_v2 <= w_c_vld;
            r_v3 <= r_v2;
            r_v5 <= w_t_vld;
            r_v6 <= r_v5;
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl <= n_dl;
            r_da <= n_da;
            r_db <= n_db;
            r_s1 <= 32'(mag16(w_p.a)) * 32'(mag16(w_p.a)) + 32'(mag16(w_p.b)) * 32'(mag16(w_p.b));
            r_s2 <= 32'(mag16(w_q.a)) * 32'(mag16(w_q.a)) + 32'(mag16(w_q.b)) * 32'(mag16(w_q.b));

            r_dl2 <= w_dl_c;
            r_dc2 <= n_dc;
            r_sab <= 33'(32'(w_side_c[31:16]) * 32'(w_side_c[31:16]))
                   + 33'(32'(w_side_c[15:0]) * 32'(w_side_c[15:0]));
            r_kc1 <= 32'(r_k1) * 32'(w_c1);
            r_kh1 <= 32'(r_k2) * 32'(w_c1);

            r_dl3 <= r_dl2;
            r_dc3 <= r_dc2;
            // clamp a negative squared hue difference
            r_dhv <= n_dh2[33] ? 33'd0 : n_dh2[32:0];
            r_sc <= 25'd65536 + 25'((33'(r_kc1) + 33'd128) >> 8);
            r_sh <= 25'd65536 + 25'((33'(r_kh1) + 33'd128) >> 8);

            r_tl2 <= 58'(w_tl) * 58'(w_tl);
            r_tc2 <= 58'(w_tc) * 58'(w_tc);
            r_th2 <= 58'(w_th) * 58'(w_th);
            r_sum <= 60'(r_tl2) + 60'(r_tc2) + 60'(r_th2);

            r_out <= (w_res > 30'd65535) ? 16'hFFFF : w_res[15:0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_delta_e_q8 = r_out;
endmodule

// ----- rtl/core/cie94_div.sv -----
// Pipelined dividers: cie94_div takes a run-time divisor, one quotient bit per stage;
// cie94_cdiv divides by an elaboration-time constant through a reciprocal product.
// Standalone; cie94_div is used by the top level, cie94_cdiv by cie94_lab.
module cie94_div #(
    parameter int NW = 34,
    parameter int DW = 25,
    parameter int QW = 29,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld  [QW];
    logic [WW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic          n_vld  [QW];
    logic [WW-1:0] n_rem  [QW];
    logic [DW-1:0] n_den  [QW];
    logic [QW-1:0] n_quo  [QW];
    logic [SW-1:0] n_side [QW];

    always_comb begin
        logic          s_vld;
        logic [WW-1:0] s_rem, s_shf;
        logic [DW-1:0] s_den;
        logic [QW-1:0] s_quo;
        logic [SW-1:0] s_side;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                s_vld = i_vld; s_rem = WW'(i_num); s_den = i_den;
                s_quo = '0; s_side = i_side;
            end else begin
                s_vld = r_vld[s-1]; s_rem = r_rem[s-1]; s_den = r_den[s-1];
                s_quo = r_quo[s-1]; s_side = r_side[s-1];
            end
            s_shf = WW'(s_den) << (QW - 1 - s);
            n_vld[s] = s_vld;
            n_den[s] = s_den;
            n_side[s] = s_side;
            n_rem[s] = s_rem;
            n_quo[s] = s_quo;
            if (s_rem >= s_shf) begin
                n_rem[s] = s_rem - s_shf;
                n_quo[s] = s_quo | (QW'(1) << (QW - 1 - s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QW; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < QW; s++) r_vld[s] <= n_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= n_den[s];
                r_quo[s] <= n_quo[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];
endmodule

// floor(num / DEN) as (num * ceil(2^SH / DEN)) >> SH, exact for every num below 2^NW
// since SH = NW + clog2(DEN); one 16-bit limb of the reciprocal per stage
module cie94_cdiv #(
    parameter int          NW  = 48,
    parameter int          QW  = 25,
    parameter int          SW  = 1,
    parameter logic [31:0] DEN = 32'd3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int SH  = NW + $clog2(DEN);
    localparam int LN  = (NW + 16) / 16;
    localparam int LW  = 16 * LN;
    localparam int PW  = NW + LW;
    localparam int MPW = NW + 16;
    localparam logic [127:0] RCP_FULL =
        ((128'd1 << SH) + 128'(DEN) - 128'd1) / 128'(DEN);
    localparam logic [LW-1:0] RCP = RCP_FULL[LW-1:0];

    logic          r_vld  [LN];
    logic [NW-1:0] r_num  [LN-1];
    logic [PW-1:0] r_acc  [LN];
    logic [SW-1:0] r_side [LN];
    logic [PW-1:0] n_acc  [LN];

    always_comb begin
        for (int k = 0; k < LN; k++) begin
            if (k == 0) begin
                n_acc[k] = PW'(MPW'(i_num) * MPW'(RCP[15:0]));
            end else begin
                n_acc[k] = r_acc[k-1]
                         + (PW'(MPW'(r_num[k-1]) * MPW'(RCP[16*k +: 16])) << (16 * k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LN; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < LN; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            for (int k = 1; k < LN - 1; k++) r_num[k] <= r_num[k-1];
            r_side[0] <= i_side;
            for (int k = 1; k < LN; k++) r_side[k] <= r_side[k-1];
            for (int k = 0; k < LN; k++) r_acc[k] <= n_acc[k];
        end
    end

    assign o_vld  = r_vld[LN-1];
    assign o_quo  = r_acc[LN-1][SH +: QW];
    assign o_side = r_side[LN-1];
endmodule

// ----- rtl/core/cie94_sqrt.sv -----
// Pipelined floor square root: one result bit per stage, square kept incrementally.
// Standalone; used by the top level.
module cie94_sqrt #(
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [VW-1:0]         i_val,
    input  logic [SW-1:0]         i_side,
    output logic                  o_vld,
    output logic [(VW+1)/2-1:0]   o_root,
    output logic [SW-1:0]         o_side
);
    localparam int RW = (VW + 1) / 2;
    localparam int CW = 2 * RW + 2;

    logic          r_vld  [RW];
    logic [VW-1:0] r_val  [RW];
    logic [RW-1:0] r_y    [RW];
    logic [CW-1:0] r_sq   [RW];
    logic [SW-1:0] r_side [RW];
    logic          n_vld  [RW];
    logic [VW-1:0] n_val  [RW];
    logic [RW-1:0] n_y    [RW];
    logic [CW-1:0] n_sq   [RW];
    logic [SW-1:0] n_side [RW];

    always_comb begin
        logic          s_vld;
        logic [VW-1:0] s_val;
        logic [RW-1:0] s_y;
        logic [CW-1:0] s_sq, cand;
        logic [SW-1:0] s_side;
        for (int s = 0; s < RW; s++) begin
            if (s == 0) begin
                s_vld = i_vld; s_val = i_val; s_y = '0; s_sq = '0; s_side = i_side;
            end else begin
                s_vld = r_vld[s-1]; s_val = r_val[s-1]; s_y = r_y[s-1];
                s_sq = r_sq[s-1]; s_side = r_side[s-1];
            end
            // (y + 2^k)^2 = y^2 + y*2^(k+1) + 2^(2k)
            cand = s_sq + (CW'(s_y) << (RW - s)) + (CW'(1) << (2 * (RW - 1 - s)));
            n_vld[s] = s_vld;
            n_val[s] = s_val;
            n_side[s] = s_side;
            n_y[s] = s_y;
            n_sq[s] = s_sq;
            if (cand <= CW'(s_val)) begin
                n_y[s] = s_y | (RW'(1) << (RW - 1 - s));
                n_sq[s] = cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RW; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < RW; s++) r_vld[s] <= n_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < RW; s++) begin
                r_val[s] <= n_val[s];
                r_y[s] <= n_y[s];
                r_sq[s] <= n_sq[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_y[RW-1];
    assign o_side = r_side[RW-1];
endmodule

// ----- rtl/core/cie94_cbrt.sv -----
// Pipelined Q24 cube root with truncated cubes: two stages per result bit
// (square, then cube and compare). Imports cie94_pkg for widths.
module cie94_cbrt
    import cie94_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [F_W-1:0] i_val,
    input  logic [SW-1:0]  i_side,
    output logic           o_vld,
    output logic [F_W-1:0] o_root,
    output logic [SW-1:0]  o_side
);
    localparam int SQW = F_W + 1;
    localparam int CBW = F_W + 2;

    // square stage
    logic           r_a_vld  [F_W];
    logic [F_W-1:0] r_a_val  [F_W];
    logic [F_W-1:0] r_a_cand [F_W];
    logic [SQW-1:0] r_a_sq   [F_W];
    logic [SW-1:0]  r_a_side [F_W];
    logic           n_a_vld  [F_W];
    logic [F_W-1:0] n_a_val  [F_W];
    logic [F_W-1:0] n_a_cand [F_W];
    logic [SQW-1:0] n_a_sq   [F_W];
    logic [SW-1:0]  n_a_side [F_W];
    // cube and compare stage
    logic           r_b_vld  [F_W];
    logic [F_W-1:0] r_b_val  [F_W];
    logic [F_W-1:0] r_b_y    [F_W];
    logic [SW-1:0]  r_b_side [F_W];
    logic           n_b_vld  [F_W];
    logic [F_W-1:0] n_b_val  [F_W];
    logic [F_W-1:0] n_b_y    [F_W];
    logic [SW-1:0]  n_b_side [F_W];

    always_comb begin
        logic           s_vld;
        logic [F_W-1:0] s_val, s_y, bit_k;
        logic [SW-1:0]  s_side;
        logic [2*F_W-1:0] sq_full;
        logic [2*F_W:0]   cb_full;
        logic [CBW-1:0]   cube;
        for (int p = 0; p < F_W; p++) begin
            if (p == 0) begin
                s_vld = i_vld; s_val = i_val; s_y = '0; s_side = i_side;
            end else begin
                s_vld = r_b_vld[p-1]; s_val = r_b_val[p-1];
                s_y = r_b_y[p-1]; s_side = r_b_side[p-1];
            end
            bit_k = F_W'(1) << (F_W - 1 - p);
            n_a_vld[p] = s_vld;
            n_a_val[p] = s_val;
            n_a_side[p] = s_side;
            n_a_cand[p] = s_y | bit_k;
            sq_full = (2*F_W)'(n_a_cand[p]) * (2*F_W)'(n_a_cand[p]);
            n_a_sq[p] = sq_full[F_FRAC +: SQW];

            cb_full = (2*F_W+1)'(r_a_sq[p]) * (2*F_W+1)'(r_a_cand[p]);
            cube = cb_full[F_FRAC +: CBW];
            n_b_vld[p] = r_a_vld[p];
            n_b_val[p] = r_a_val[p];
            n_b_side[p] = r_a_side[p];
            // keep the bit only if the truncated cube stays at or below the input
            n_b_y[p] = (cube <= CBW'(r_a_val[p])) ? r_a_cand[p] : (r_a_cand[p] & ~bit_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < F_W; p++) begin
                r_a_vld[p] <= 1'b0;
                r_b_vld[p] <= 1'b0;
            end
        end else if (i_en) begin
            for (int p = 0; p < F_W; p++) begin
                r_a_vld[p] <= n_a_vld[p];
                r_b_vld[p] <= n_b_vld[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < F_W; p++) begin
                r_a_val[p] <= n_a_val[p];
                r_a_cand[p] <= n_a_cand[p];
                r_a_sq[p] <= n_a_sq[p];
                r_a_side[p] <= n_a_side[p];
                r_b_val[p] <= n_b_val[p];
                r_b_y[p] <= n_b_y[p];
                r_b_side[p] <= n_b_side[p];
            end
        end
    end

    assign o_vld  = r_b_vld[F_W-1];
    assign o_root = r_b_y[F_W-1];
    assign o_side = r_b_side[F_W-1];
endmodule

// ----- rtl/core/cie94_lab.sv -----
// sRGB to Lab pipeline for one color: gamma table, D65 matrix, white-point divide,
// Lab function, Q8.8 rounding. Uses cie94_pkg, cie94_cdiv and cie94_cbrt.
module cie94_lab
    import cie94_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_vld,
    output t_lab       o_lab
);
    logic             r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_lin             r_lin [3];
    logic [40:0]      r_prod [3][3];
    logic [47:0]      r_num [3];
    logic [33:0]      r_ln [3];
    logic             r_sm [3];
    logic [F_W-1:0]   r_xv [3];
    logic signed [35:0] r_lm, r_am, r_bm;
    t_lab             r_lab;

    logic [39:0]      n_ln [3];
    logic             n_sm [3];
    logic [39:0]      w_lsp [3];
    logic             w_vld_a [3], w_vld_b [3], w_vld_c [3];
    logic [F_W-1:0]   w_v [3], w_cy [3], w_f [3];
    logic [21:0]      w_lq [3];
    logic [F_W:0]     w_ls [3];
    logic [22:0]      w_cs [3];
    logic signed [35:0] n_lm, n_am, n_bm;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_lsp[c] = 40'(w_v[c]) * 40'(LSEG_MUL);
            n_ln[c] = w_lsp[c] + LSEG_OFS;
            n_sm[c] = (w_lsp[c] <= LSEG_LIM);
            w_f[c] = w_cs[c][22] ? F_W'(w_cs[c][21:0]) : w_cy[c];
        end
        n_lm = $signed(36'(w_f[1]) * 36'd116) - $signed(36'd16 << F_FRAC);
        n_am = ($signed(36'(w_f[0])) - $signed(36'(w_f[1]))) * 36'sd500;
        n_bm = ($signed(36'(w_f[1])) - $signed(36'(w_f[2]))) * 36'sd200;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= w_vld_a[0]; r_v5 <= w_vld_c[0]; r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin[0] <= LIN_TAB[i_red];
            r_lin[1] <= LIN_TAB[i_green];
            r_lin[2] <= LIN_TAB[i_blue];
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) r_prod[c][j] <= 41'(MAT[c][j]) * 41'(r_lin[j]);
                r_num[c] <= (48'(43'(r_prod[c][0]) + 43'(r_prod[c][1]) + 43'(r_prod[c][2])) << 8)
                            + 48'(WHITE_DEN[c] / 2);
                // the segment sum stays below 2^34 wherever the linear branch is taken
                r_ln[c] <= n_ln[c][33:0];
                r_sm[c] <= n_sm[c];
                r_xv[c] <= w_v[c];
            end
            r_lm <= n_lm;
            r_am <= n_am;
            r_bm <= n_bm;
            r_lab.l <= to_q8(r_lm);
            r_lab.a <= to_q8(r_am);
            r_lab.b <= to_q8(r_bm);
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        cie94_cdiv #(.NW(48), .QW(F_W), .SW(1), .DEN(32'(WHITE_DEN[c]))) u_div_wp (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_vld(r_v3), .i_num(r_num[c]), .i_side(1'b0),
            .o_vld(w_vld_a[c]), .o_quo(w_v[c]), .o_side()
        );

        cie94_cdiv #(.NW(34), .QW(22), .SW(F_W + 1), .DEN(32'(LSEG_DEN))) u_div_seg (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_vld(r_v4), .i_num(r_ln[c]), .i_side({r_sm[c], r_xv[c]}),
            .o_vld(w_vld_b[c]), .o_quo(w_lq[c]), .o_side(w_ls[c])
        );

        cie94_cbrt #(.SW(23)) u_cbrt (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_vld(w_vld_b[c]), .i_val(w_ls[c][F_W-1:0]), .i_side({w_ls[c][F_W], w_lq[c]}),
            .o_vld(w_vld_c[c]), .o_root(w_cy[c]), .o_side(w_cs[c])
        );
    end

    assign o_vld = r_v6;
    assign o_lab = r_lab;
endmodule

// ----- rtl/core/cie94_chk.sv -----
// Port-level checks for rgb_pair_cie94_delta_e and the bind that attaches them.
// Uses only the top level's clock, reset, handshake and result ports.
module cie94_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_delta_e_q8
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_delta_e_q8))
        else $error("result changed while stalled");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("item taken while the pipeline is held");

    a_free_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input blocked with a free output");
endmodule

bind rgb_pair_cie94_delta_e cie94_chk u_cie94_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_delta_e_q8(o_delta_e_q8)
);
